FILE: rtl/segi2d_pkg.sv
// ----------------------------------------------------------------------------
// segi2d_pkg
// widths, codes and side-band types shared by the segment crossing block
// ----------------------------------------------------------------------------
package segi2d_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CW        = 32;
  localparam int TOLW      = 16;
  localparam int DW        = CW + 1;
  localparam int PW        = 2 * DW;
  localparam int XW        = PW + 1;
  localparam int EW        = XW + TOLW;
  localparam int SW        = EW + FRAC_BITS + 2;
  localparam int MW        = XW + FRAC_BITS;
  localparam int QB        = FRAC_BITS + 2;
  localparam int DVW       = MW + QB;
  localparam int TQW       = QB + 1;
  localparam int TW        = TQW + DW;
  localparam int NST       = QB + 9;

  localparam logic [TOLW-1:0] TOL_RESET = TOLW'(66);

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_MISS     = 2'd1,
    ST_PARALLEL = 2'd2
  } status_e;

  typedef struct packed {
    logic                 par;
    logic                 ok;
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [DW-1:0] r_x;
    logic signed [DW-1:0] r_y;
  } side_t;

endpackage

FILE: rtl/segi2d_if.sv
// ----------------------------------------------------------------------------
// segi2d_if
// valid/ready channels for segment pairs and crossing results
// ----------------------------------------------------------------------------
interface segi2d_in_if;
  logic                 valid;
  logic                 ready;
  logic signed [31:0]   a_x;
  logic signed [31:0]   a_y;
  logic signed [31:0]   b_x;
  logic signed [31:0]   b_y;
  logic signed [31:0]   c_x;
  logic signed [31:0]   c_y;
  logic signed [31:0]   d_x;
  logic signed [31:0]   d_y;

  modport source (output valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y, input ready);
  modport sink   (input valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y, output ready);
endinterface

interface segi2d_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] hit_x;
  logic signed [31:0] hit_y;

  modport source (output valid, status, hit_x, hit_y, input ready);
  modport sink   (input valid, status, hit_x, hit_y, output ready);
endinterface

FILE: rtl/segment_intersection_2d.sv
// ----------------------------------------------------------------------------
// segment_intersection_2d
// 2d segment crossing test with saturated Q16.16 crossing point
// ----------------------------------------------------------------------------
// seg_i takes one beat per segment pair (a->b, c->d, signed Q16.16).
// res_o gives one beat per pair: status (cross, no crossing, parallel)
// and the crossing point, zero unless the segments cross.
// tol_we_i/tol_wdata_i write the tolerance, slack beyond 0 and 1 for both
// segment parameters; write it only while no beat is in flight.
// the pipeline has six stages of differences, products,
// cross sums, sign fix, tolerance scaling and window test, one stage per
// quotient bit of the restoring divider (18 bits), then rounding, the
// product with the direction and the saturating add.
// throughput is one beat per cycle while res_o does not stall.
// reset empties the pipeline and sets the tolerance to 66 (about 0.001).
// when res_o stalls the whole pipeline holds; seg_i.ready stays high while
// the output register is empty or being taken.
// ----------------------------------------------------------------------------
module segment_intersection_2d import segi2d_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            tol_we_i,
  input  logic [TOLW-1:0] tol_wdata_i,
  segi2d_in_if.sink       seg_i,
  segi2d_out_if.source    res_o
);

  logic [TOLW-1:0] tol_q;
  logic [NST-1:0]  v_q;
  logic            en;

  assign en          = !v_q[NST-1] || res_o.ready;
  assign seg_i.ready = en;
  assign res_o.valid = v_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (tol_we_i) begin
      tol_q <= tol_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-2:0], seg_i.valid && en};
    end
  end

  // stage 1: differences
  logic signed [DW-1:0] rx1_q, ry1_q, sx1_q, sy1_q, qx1_q, qy1_q;
  logic signed [CW-1:0] ax1_q, ay1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rx1_q <= DW'(seg_i.b_x) - DW'(seg_i.a_x);
      ry1_q <= DW'(seg_i.b_y) - DW'(seg_i.a_y);
      sx1_q <= DW'(seg_i.d_x) - DW'(seg_i.c_x);
      sy1_q <= DW'(seg_i.d_y) - DW'(seg_i.c_y);
      qx1_q <= DW'(seg_i.c_x) - DW'(seg_i.a_x);
      qy1_q <= DW'(seg_i.c_y) - DW'(seg_i.a_y);
      ax1_q <= seg_i.a_x;
      ay1_q <= seg_i.a_y;
    end
  end

  // stage 2: products
  logic signed [PW-1:0] p_rs_q, p_sr_q, p_qs_q, p_sq_q, p_qr_q, p_rq_q;
  side_t                sd2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_rs_q <= PW'(rx1_q) * PW'(sy1_q);
      p_sr_q <= PW'(ry1_q) * PW'(sx1_q);
      p_qs_q <= PW'(qx1_q) * PW'(sy1_q);
      p_sq_q <= PW'(qy1_q) * PW'(sx1_q);
      p_qr_q <= PW'(qx1_q) * PW'(ry1_q);
      p_rq_q <= PW'(qy1_q) * PW'(rx1_q);
      sd2_q  <= '{par: 1'b0, ok: 1'b0, a_x: ax1_q, a_y: ay1_q, r_x: rx1_q, r_y: ry1_q};
    end
  end

  // stage 3: cross products
  logic signed [XW-1:0] den3_q, tn3_q, un3_q;
  side_t                sd3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      den3_q <= XW'(p_rs_q) - XW'(p_sr_q);
      tn3_q  <= XW'(p_qs_q) - XW'(p_sq_q);
      un3_q  <= XW'(p_qr_q) - XW'(p_rq_q);
      sd3_q  <= sd2_q;
    end
  end

  // stage 4: make the denominator positive
  logic signed [XW-1:0] den4_q, tn4_q, un4_q;
  side_t                sd4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      den4_q <= den3_q[XW-1] ? -den3_q : den3_q;
      tn4_q  <= den3_q[XW-1] ? -tn3_q  : tn3_q;
      un4_q  <= den3_q[XW-1] ? -un3_q  : un3_q;
      sd4_q  <= '{par: (den3_q == '0), ok: sd3_q.ok, a_x: sd3_q.a_x, a_y: sd3_q.a_y,
                  r_x: sd3_q.r_x, r_y: sd3_q.r_y};
    end
  end

  // stage 5: tolerance times denominator
  logic signed [XW-1:0] den5_q, tn5_q, un5_q;
  logic [EW-1:0]        ed5_q;
  side_t                sd5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ed5_q  <= EW'($unsigned(den4_q)) * EW'(tol_q);
      den5_q <= den4_q;
      tn5_q  <= tn4_q;
      un5_q  <= un4_q;
      sd5_q  <= sd4_q;
    end
  end

  // stage 6: window test and divider setup
  logic signed [SW-1:0] ns6, nu6, ds6, ed6;
  logic                 t_ok, u_ok;
  logic [XW-1:0]        tmag6;

  assign ds6   = SW'(den5_q) <<< FRAC_BITS;
  assign ns6   = SW'(tn5_q) <<< FRAC_BITS;
  assign nu6   = SW'(un5_q) <<< FRAC_BITS;
  assign ed6   = signed'(SW'(ed5_q));
  assign t_ok  = !((ns6 + ed6) < 0) && !((ds6 + ed6 - ns6) < 0);
  assign u_ok  = !((nu6 + ed6) < 0) && !((ds6 + ed6 - nu6) < 0);
  assign tmag6 = tn5_q[XW-1] ? $unsigned(-tn5_q) : $unsigned(tn5_q);

  logic [DVW-1:0] rem_q [QB+1];
  logic [XW-1:0]  dv_q  [QB+1];
  logic [QB-1:0]  quo_q [QB+1];
  logic           neg_q [QB+1];
  side_t          sdv_q [QB+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q[0] <= DVW'(tmag6) << FRAC_BITS;
      dv_q[0]  <= $unsigned(den5_q);
      quo_q[0] <= '0;
      neg_q[0] <= tn5_q[XW-1];
      sdv_q[0] <= '{par: sd5_q.par, ok: t_ok && u_ok, a_x: sd5_q.a_x, a_y: sd5_q.a_y,
                    r_x: sd5_q.r_x, r_y: sd5_q.r_y};
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [DVW-1:0] dsh;
    logic           ge;

    assign dsh = DVW'(dv_q[k]) << (QB - 1 - k);
    assign ge  = (rem_q[k] >= dsh);

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[k+1] <= ge ? rem_q[k] - dsh : rem_q[k];
        quo_q[k+1] <= quo_q[k] | (ge ? QB'(1) << (QB - 1 - k) : '0);
        dv_q[k+1]  <= dv_q[k];
        neg_q[k+1] <= neg_q[k];
        sdv_q[k+1] <= sdv_q[k];
      end
    end
  end

  // floor correction and sign
  logic [TQW-1:0]        qm;
  logic signed [TQW-1:0] tq_q;
  side_t                 sdf_q;

  assign qm = TQW'(quo_q[QB]) + TQW'(neg_q[QB] && (rem_q[QB] != '0));

  always_ff @(posedge clk_i) begin
    if (en) begin
      tq_q  <= neg_q[QB] ? -signed'(qm) : signed'(qm);
      sdf_q <= sdv_q[QB];
    end
  end

  // t times direction
  logic signed [TW-1:0] px_q, py_q;
  side_t                sdm_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q  <= TW'(tq_q) * TW'(sdf_q.r_x);
      py_q  <= TW'(tq_q) * TW'(sdf_q.r_y);
      sdm_q <= sdf_q;
    end
  end

  // saturating add and result
  logic signed [TW:0]   hx_sum, hy_sum;
  logic signed [CW-1:0] hx_sat, hy_sat;
  logic                 hit;

  assign hx_sum = (TW+1)'(sdm_q.a_x) + (TW+1)'(px_q >>> FRAC_BITS);
  assign hy_sum = (TW+1)'(sdm_q.a_y) + (TW+1)'(py_q >>> FRAC_BITS);
  assign hit    = !sdm_q.par && sdm_q.ok;

  always_comb begin
    hx_sat = hx_sum[CW-1:0];
    hy_sat = hy_sum[CW-1:0];
    if (!hx_sum[TW] && (hx_sum[TW:CW-1] != '0)) hx_sat = {1'b0, {(CW-1){1'b1}}};
    if (hx_sum[TW] && (hx_sum[TW:CW-1] != '1))  hx_sat = {1'b1, {(CW-1){1'b0}}};
    if (!hy_sum[TW] && (hy_sum[TW:CW-1] != '0)) hy_sat = {1'b0, {(CW-1){1'b1}}};
    if (hy_sum[TW] && (hy_sum[TW:CW-1] != '1))  hy_sat = {1'b1, {(CW-1){1'b0}}};
  end

  status_e              st_q;
  logic signed [CW-1:0] hx_q, hy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q <= sdm_q.par ? ST_PARALLEL : (sdm_q.ok ? ST_HIT : ST_MISS);
      hx_q <= hit ? hx_sat : '0;
      hy_q <= hit ? hy_sat : '0;
    end
  end

  assign res_o.status = st_q;
  assign res_o.hit_x  = hx_q;
  assign res_o.hit_y  = hy_q;

  a_no_bad_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (st_q == ST_HIT || st_q == ST_MISS || st_q == ST_PARALLEL))
    else $error("invalid status code");

  a_zero_on_miss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && st_q != ST_HIT) |-> (hx_q == '0 && hy_q == '0))
    else $error("nonzero point without crossing");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q))
    else $error("pipeline moved during stall");

  a_parallel_zero_den : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && v_q[3]) |=> (sd5_q.par == (den5_q == '0)))
    else $error("parallel flag mismatch");

endmodule

FILE: verif/segment_intersection_2d_tb.sv
// ----------------------------------------------------------------------------
// segment_intersection_2d_tb
// self-checking bench for the 2d segment crossing block: directed corner
// cases, several tolerance settings and random segment pairs with and without
// random idling on both channels, checked against an exact crossing predictor
// ----------------------------------------------------------------------------
module segment_intersection_2d_tb;
  import segi2d_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_e     status;
    logic [31:0] hit_x;
    logic [31:0] hit_y;
  } crossing_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic tol_we_i = 1'b0;
  logic [TOLW-1:0] tol_wdata_i = '0;

  segi2d_in_if  seg_if ();
  segi2d_out_if res_if ();

  segment_intersection_2d dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tol_we_i    (tol_we_i),
    .tol_wdata_i (tol_wdata_i),
    .seg_i       (seg_if.sink),
    .res_o       (res_if.source)
  );

  always #6 clk_i = ~clk_i;

  crossing_t       crossing_q[$];
  logic [TOLW-1:0] tol_m = TOL_RESET;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  int              n_fail = 0;
  int              n_sent = 0;
  int              n_hit = 0;
  int              n_miss = 0;
  int              n_par = 0;

  function automatic crossing_t predict_crossing(logic signed [31:0] ax, logic signed [31:0] ay,
                                                 logic signed [31:0] bx, logic signed [31:0] by,
                                                 logic signed [31:0] cx, logic signed [31:0] cy,
                                                 logic signed [31:0] dx, logic signed [31:0] dy);
    logic signed [39:0]  rx, ry, sx, sy, qx, qy;
    logic signed [127:0] den, tn, un, ed, ns, ds, tq, px, py;
    crossing_t res;
    rx = 40'(bx) - 40'(ax);
    ry = 40'(by) - 40'(ay);
    sx = 40'(dx) - 40'(cx);
    sy = 40'(dy) - 40'(cy);
    qx = 40'(cx) - 40'(ax);
    qy = 40'(cy) - 40'(ay);
    res.status = ST_MISS;
    res.hit_x = '0;
    res.hit_y = '0;
    den = 128'(rx) * 128'(sy) - 128'(ry) * 128'(sx);
    if (den == 0) begin
      res.status = ST_PARALLEL;
      return res;
    end
    tn = 128'(qx) * 128'(sy) - 128'(qy) * 128'(sx);
    un = 128'(qx) * 128'(ry) - 128'(qy) * 128'(rx);
    if (den < 0) begin
      den = -den;
      tn = -tn;
      un = -un;
    end
    ed = den * $signed({1'b0, tol_m});
    ds = den <<< FRAC_BITS;
    ns = tn <<< FRAC_BITS;
    if (ns + ed < 0 || ds + ed - ns < 0) return res;
    ns = un <<< FRAC_BITS;
    if (ns + ed < 0 || ds + ed - ns < 0) return res;
    ns = tn <<< FRAC_BITS;
    tq = ns / den;
    if (ns < 0 && tq * den != ns) tq = tq - 1;
    if (tq > (128'sd1 <<< 28)) tq = 128'sd1 <<< 28;
    if (tq < -(128'sd1 <<< 28)) tq = -(128'sd1 <<< 28);
    px = 128'(ax) + ((tq * 128'(rx)) >>> FRAC_BITS);
    py = 128'(ay) + ((tq * 128'(ry)) >>> FRAC_BITS);
    if (px > 128'sd2147483647) px = 128'sd2147483647;
    if (px < -128'sd2147483648) px = -128'sd2147483648;
    if (py > 128'sd2147483647) py = 128'sd2147483647;
    if (py < -128'sd2147483648) py = -128'sd2147483648;
    res.status = ST_HIT;
    res.hit_x = px[31:0];
    res.hit_y = py[31:0];
    return res;
  endfunction

  task automatic send_pair(logic [31:0] ax, logic [31:0] ay, logic [31:0] bx, logic [31:0] by,
                           logic [31:0] cx, logic [31:0] cy, logic [31:0] dx, logic [31:0] dy);
    while ($urandom_range(99) < send_idle_pct) begin
      seg_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    seg_if.valid <= 1'b1;
    seg_if.a_x <= ax; seg_if.a_y <= ay; seg_if.b_x <= bx; seg_if.b_y <= by;
    seg_if.c_x <= cx; seg_if.c_y <= cy; seg_if.d_x <= dx; seg_if.d_y <= dy;
    do @(posedge clk_i); while (!seg_if.ready);
    crossing_q = {crossing_q, predict_crossing(ax, ay, bx, by, cx, cy, dx, dy)};
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_and_settle();
    int guard;
    guard = 0;
    seg_if.valid <= 1'b0;
    while (crossing_q.size() != 0 && guard < 200000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (NST + 5) @(negedge clk_i);
  endtask

  task automatic write_tolerance(logic [TOLW-1:0] val);
    drain_and_settle();
    tol_we_i <= 1'b1;
    tol_wdata_i <= val;
    @(negedge clk_i);
    tol_we_i <= 1'b0;
    tol_m = val;
  endtask

  // output checker
  always @(posedge clk_i) begin
    crossing_t exp_c;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (crossing_q.size() == 0) begin
        $error("result beat with nothing expected");
        n_fail++;
      end else begin
        exp_c = crossing_q.pop_front();
        case (exp_c.status)
          ST_HIT: n_hit++;
          ST_MISS: n_miss++;
          default: n_par++;
        endcase
        if (res_if.status !== exp_c.status) begin
          $error("status: expected %0d, got %0d", exp_c.status, res_if.status);
          n_fail++;
        end
        if (res_if.hit_x !== exp_c.hit_x) begin
          $error("hit_x: expected %h, got %h", exp_c.hit_x, res_if.hit_x);
          n_fail++;
        end
        if (res_if.hit_y !== exp_c.hit_y) begin
          $error("hit_y: expected %h, got %h", exp_c.hit_y, res_if.hit_y);
          n_fail++;
        end
      end
    end
  end

  always @(negedge clk_i) res_if.ready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic test_directed();
    logic [31:0] mx, mn, one;
    mx = 32'h7fffffff; mn = 32'h80000000; one = 32'h00010000;
    send_pair(0, 0, 2*one, 2*one, 0, 2*one, 2*one, 0);
    send_pair(0, 0, one, 0, 0, one, one, one);
    send_pair(0, 0, 0, 0, 5, 5, 9, 1);
    send_pair(3, 3, 7, 9, 1, 1, 1, 1);
    send_pair(0, 0, one, 0, one, -one, one, one);
    send_pair(0, 0, one, 0, one + 66, -one, one + 66, one);
    send_pair(0, 0, one, 0, one + 67, -one, one + 67, one);
    send_pair(0, 0, one, 0, -66, -one, -66, one);
    send_pair(0, 0, one, 0, -67, -one, -67, one);
    send_pair(mn, mn, mx, mx, mn, mx, mx, mn);
    send_pair(mx, mx, mn, mn, mx, mn, mn, mx);
    send_pair(mn, 0, mx, 0, 0, mn, 0, mx);
    send_pair(mx, mn, mn, mx, mn, mn, mx, mx);
    send_pair(0, 0, 3*one, one, one, 3*one, 2*one, -one);
    send_pair(0, 0, one, 0, 2*one, -one, 2*one, one);
    send_pair(mn, mn, mn, mx, mx, mn, mx, mx);
    send_pair(32'hffffffff, 32'hffffffff, 1, 1, 32'hffffffff, 1, 1, 32'hffffffff);
    send_pair(0, 0, one, one, 0, 0, one, one);
  endtask

  task automatic test_tolerance_sweep();
    logic [TOLW-1:0] tols[4];
    tols = '{16'd0, 16'hffff, 16'd1, 16'd4096};
    foreach (tols[k]) begin
      write_tolerance(tols[k]);
      send_pair(0, 0, 32'h10000, 0, 32'h10000 + tols[k], -5, 32'h10000 + tols[k], 5);
      send_pair(0, 0, 32'h10000, 0, 32'h10001 + tols[k], -5, 32'h10001 + tols[k], 5);
      send_pair(0, 0, 32'h10000, 0, -tols[k], -5, -tols[k], 5);
      send_pair(0, 0, 32'h10000, 0, -tols[k] - 1, -5, -tols[k] - 1, 5);
      send_pair(0, 0, 32'h20000, 32'h20000, 0, 32'h20000, 32'h20000, 0);
    end
  endtask

  function automatic logic [31:0] rand_coord(int sel);
    case (sel)
      0: return $urandom();
      1: return $signed($urandom_range(65535)) - 32768;
      default: return $signed($urandom_range(32'h1000000)) - 32'sh800000;
    endcase
  endfunction

  task automatic test_random(int n);
    logic [31:0] v[8];
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(9) == 0 ? 0 : $urandom_range(1, 2);
      foreach (v[k]) v[k] = rand_coord(sel);
      if ($urandom_range(9) == 0) begin
        v[2] = v[0]; v[3] = v[1];
      end
      if ($urandom_range(9) == 0) begin
        v[6] = v[4] + (v[2] - v[0]); v[7] = v[5] + (v[3] - v[1]);
      end
      if ($urandom_range(49) == 0) foreach (v[k]) v[k] = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      send_pair(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
    end
  endtask

  initial begin
    seg_if.valid = 1'b0;
    {seg_if.a_x, seg_if.a_y, seg_if.b_x, seg_if.b_y} = '0;
    {seg_if.c_x, seg_if.c_y, seg_if.d_x, seg_if.d_y} = '0;
    res_if.ready = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_tolerance_sweep();
    write_tolerance(TOL_RESET);
    send_idle_pct = 26; recv_idle_pct = 51;
    test_random(350);
    write_tolerance($urandom_range(65535));
    send_idle_pct = 51; recv_idle_pct = 26;
    test_random(350);
    write_tolerance(16'hffff);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(400);
    drain_and_settle();
    if (crossing_q.size() != 0) begin
      $error("%0d results never arrived", crossing_q.size());
      n_fail++;
    end
    $display("sent %0d segment pairs: %0d crossing, %0d apart, %0d parallel",
             n_sent, n_hit, n_miss, n_par);
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(20ms);
    $display("FAILURE");
    $finish;
  end

endmodule
